>>> hdl/srst_pkg.sv
// Shared types, codes and widths for the stepper ramp step timer.
`default_nettype none

package srst_pkg;

  localparam int SRST_TABLE_DEPTH = 256;

  localparam int IN_TDATA_W  = 24;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 72;
  localparam int OUT_TUSER_W = 3;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;

  // phase codes as seen on the result channel
  localparam logic [2:0] PH_IDLE     = 3'd0;
  localparam logic [2:0] PH_STARTED  = 3'd1;
  localparam logic [2:0] PH_ACCEL    = 3'd2;
  localparam logic [2:0] PH_CRUISE   = 3'd3;
  localparam logic [2:0] PH_DECEL    = 3'd4;
  localparam logic [2:0] PH_FINISHED = 3'd5;

  typedef enum logic [1:0] {
    OP_STEP  = 2'd0,
    OP_WRITE = 2'd1,
    OP_START = 2'd2
  } opcode_t;

  typedef enum logic [2:0] {
    CFG_TOTAL_STEPS   = 3'd0,
    CFG_ACCEL_STEPS   = 3'd1,
    CFG_CRUISE_STEPS  = 3'd2,
    CFG_TRAPEZOIDAL   = 3'd3,
    CFG_REPEAT_FACTOR = 3'd4,
    CFG_END_DELAY     = 3'd5,
    CFG_TABLE_SIZE    = 3'd6,
    CFG_CCW           = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [31:0] total_steps;
    logic [31:0] accel_steps;
    logic [31:0] accel_cruise;  // accel_steps + cruise_steps, wraps
    logic        trapezoidal;
    logic [7:0]  repeat_factor;
    logic [15:0] end_delay;
    logic [8:0]  table_size;
    logic        counterclockwise;
  } srst_cfg_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  table_addr;
    logic [15:0] table_data;
  } srst_item_t;

  typedef struct packed {
    logic               step_toggle;
    logic [15:0]        next_delay;
    logic [15:0]        compare_value;
    logic signed [31:0] position;
    logic [2:0]         phase;
    logic               finished;
  } srst_res_t;

endpackage

`default_nettype wire

>>> hdl/srst_ramp_mem.sv
// Ramp delay table: one write port, two registered read ports with write forwarding.
`default_nettype none

module srst_ramp_mem #(
  parameter int DEPTH = srst_pkg::SRST_TABLE_DEPTH,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [15:0]   wdata,
  input  wire logic [AW-1:0] raddr_a,
  input  wire logic [AW-1:0] raddr_b,
  output logic      [15:0]   rdata_a,
  output logic      [15:0]   rdata_b
);
  import srst_pkg::*;

  logic [15:0] mem [DEPTH];
  logic [15:0] rdata_a_r;
  logic [15:0] rdata_b_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // a write in the same cycle is forwarded into the registered data of a matching read
  always_ff @(posedge clk) begin
    rdata_a_r <= (we && (waddr == raddr_a)) ? wdata : mem[raddr_a];
    rdata_b_r <= (we && (waddr == raddr_b)) ? wdata : mem[raddr_b];
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

`default_nettype wire

>>> hdl/srst_core.sv
// Step state update: phase sequencing, ramp table lookup, position and compare value.
`default_nettype none

module srst_core #(
  parameter int TABLE_DEPTH = srst_pkg::SRST_TABLE_DEPTH
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire srst_pkg::srst_cfg_t  cfg,
  input  wire srst_pkg::srst_item_t item,
  input  wire logic               fire,
  output logic                    has_result,
  output srst_pkg::srst_res_t     res
);
  import srst_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int IW = (AW > 8) ? AW : 8;

  typedef enum logic [2:0] {
    S_IDLE     = PH_IDLE,
    S_STARTED  = PH_STARTED,
    S_ACCEL    = PH_ACCEL,
    S_CRUISE   = PH_CRUISE,
    S_DECEL    = PH_DECEL,
    S_FINISHED = PH_FINISHED
  } state_t;

  state_t             state_r,  state_nxt;
  logic [31:0]        steps_r,  steps_nxt;
  logic signed [31:0] pos_r,    pos_nxt;
  logic [7:0]         rep_r,    rep_nxt;
  logic [7:0]         idx_r,    idx_nxt;
  logic [15:0]        cmp_r,    cmp_nxt;

  logic          running;
  logic          addr_ok;
  logic          mem_we;
  logic [7:0]    last_idx;
  logic [IW-1:0] raddr_a_ext;
  logic [IW-1:0] raddr_b_ext;
  logic [IW-1:0] waddr_ext;
  logic [15:0]   rd_a;
  logic [15:0]   rd_b;
  opcode_t       op;

  assign op       = opcode_t'(item.opcode);
  assign running  = (state_r == S_STARTED) || (state_r == S_ACCEL) ||
                    (state_r == S_CRUISE)  || (state_r == S_DECEL);
  assign has_result = (op == OP_STEP) && running;
  assign addr_ok  = 32'(item.table_addr) < 32'(TABLE_DEPTH);
  assign last_idx = cfg.table_size[7:0] - 8'd1;

  assign raddr_a_ext = IW'(idx_nxt);
  assign raddr_b_ext = IW'(last_idx);
  assign waddr_ext   = IW'(item.table_addr);

  srst_ramp_mem #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (waddr_ext[AW-1:0]),
    .wdata   (item.table_data),
    .raddr_a (raddr_a_ext[AW-1:0]),
    .raddr_b (raddr_b_ext[AW-1:0]),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  always_comb begin
    logic [31:0] steps_inc;
    state_t      st2;
    logic [7:0]  idx2;
    logic [7:0]  rep2;
    logic [7:0]  rep_inc;
    logic        dec_enter;
    logic        idx_ok;
    logic [15:0] dly;
    logic        fin;

    state_nxt = state_r;
    steps_nxt = steps_r;
    pos_nxt   = pos_r;
    rep_nxt   = rep_r;
    idx_nxt   = idx_r;
    cmp_nxt   = cmp_r;
    mem_we    = 1'b0;
    steps_inc = steps_r + 32'd1;
    st2       = state_r;
    idx2      = idx_r;
    rep2      = rep_r;
    rep_inc   = 8'd0;
    dec_enter = 1'b0;
    idx_ok    = 1'b0;
    dly       = 16'd0;
    fin       = 1'b0;

    if (fire) begin
      unique case (op)
        OP_WRITE: mem_we = addr_ok;
        OP_START: begin
          steps_nxt = 32'd0;
          rep_nxt   = 8'd0;
          idx_nxt   = 8'd0;
          state_nxt = S_STARTED;
        end
        OP_STEP: begin
          if (running) begin
            steps_nxt = steps_inc;
            pos_nxt   = cfg.counterclockwise ? pos_r + 32'sd1 : pos_r - 32'sd1;
            if (steps_inc >= cfg.total_steps) begin
              state_nxt = S_FINISHED;
              fin       = 1'b1;
            end else begin
              unique case (state_r)
                S_STARTED: begin
                  st2  = S_ACCEL;
                  rep2 = 8'd0;
                  idx2 = 8'd0;
                end
                S_ACCEL: begin
                  if (steps_inc > cfg.accel_steps) begin
                    if (cfg.trapezoidal) st2 = S_CRUISE;
                    else                 dec_enter = 1'b1;
                  end
                end
                S_CRUISE: begin
                  if (steps_inc > cfg.accel_cruise) dec_enter = 1'b1;
                end
                default: ;
              endcase
              if (dec_enter) begin
                st2  = S_DECEL;
                rep2 = 8'd0;
                idx2 = last_idx;
              end
              idx_ok = ({1'b0, idx2} < cfg.table_size) &&
                       (32'(idx2) < 32'(TABLE_DEPTH));
              if (((st2 == S_ACCEL) || (st2 == S_DECEL)) && idx_ok) begin
                // the decel entry point comes from the second read port
                dly     = dec_enter ? rd_b : rd_a;
                rep_inc = rep2 + 8'd1;
                if (rep_inc >= cfg.repeat_factor) begin
                  rep2 = 8'd0;
                  if (st2 == S_ACCEL) begin
                    if (idx2 != 8'hFF) idx2 = idx2 + 8'd1;
                  end else if (idx2 != 8'h00) begin
                    idx2 = idx2 - 8'd1;
                  end
                end else begin
                  rep2 = rep_inc;
                end
              end else begin
                dly = cfg.end_delay;
              end
              state_nxt = st2;
              idx_nxt   = idx2;
              rep_nxt   = rep2;
              cmp_nxt   = cmp_r + dly;
            end
          end
        end
        default: ;
      endcase
    end

    res.step_toggle   = 1'b1;
    res.next_delay    = dly;
    res.compare_value = cmp_nxt;
    res.position      = pos_nxt;
    res.phase         = state_nxt;
    res.finished      = fin;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      steps_r <= 32'd0;
      pos_r   <= 32'sd0;
      rep_r   <= 8'd0;
      idx_r   <= 8'd0;
      cmp_r   <= 16'd0;
    end else begin
      state_r <= state_nxt;
      steps_r <= steps_nxt;
      pos_r   <= pos_nxt;
      rep_r   <= rep_nxt;
      idx_r   <= idx_nxt;
      cmp_r   <= cmp_nxt;
    end
  end

endmodule

`default_nettype wire

>>> hdl/stepper_ramp_step_timer_top.sv
// Top level of the stepper ramp step timer: channels, configuration, input and result registers.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------------------
//  in_     | slave     | in_tvalid/in_tready  | tuser opcode, tdata table addr and data
//  out_    | master    | out_tvalid/out_tready| tdata step/delay/compare/position, tuser
//          |           |                      | phase, tlast finished
//  cfg_    | slave     | cfg_valid/cfg_ready  | cfg_index, cfg_data (always ready)
//
// One transaction per clock sustained while the result channel is not stalled: an item is
// registered, updated combinationally against the state registers and the two registered ramp
// table reads, and lands in the result register, which drives out_tvalid.
// Synchronous active-low reset clears the control state and phase goes idle; the ramp
// table keeps whatever it holds and is valid only where written.
// A stalled result holds the next step item in the input register; table writes, start
// items and ignored steps drain even while the output is stalled.
`default_nettype none

module stepper_ramp_step_timer_top #(
  parameter int TABLE_DEPTH = srst_pkg::SRST_TABLE_DEPTH
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // in_tdata: table_addr[7:0], table_data[23:8]
  input  wire logic [srst_pkg::IN_TDATA_W-1:0]    in_tdata,
  // in_tuser: opcode[1:0]
  input  wire logic [srst_pkg::IN_TUSER_W-1:0]    in_tuser,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // out_tdata: step_toggle[0], next_delay[16:1], compare_value[32:17],
  //            position[64:33], zero pad[71:65]
  output logic [srst_pkg::OUT_TDATA_W-1:0]        out_tdata,
  // out_tuser: phase[2:0]
  output logic [srst_pkg::OUT_TUSER_W-1:0]        out_tuser,
  output logic                                    out_tlast,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [srst_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [srst_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import srst_pkg::*;

  // configuration registers
  logic [31:0] total_r;
  logic [31:0] accel_r;
  logic [31:0] cruise_r;
  logic        trap_r;
  logic [7:0]  repeat_r;
  logic [15:0] end_delay_r;
  logic [8:0]  table_size_r;
  logic        ccw_r;
  logic [31:0] accel_cruise_r;  // registered sum, settles while idle

  srst_cfg_t  cfg;
  srst_item_t in_item_r;
  logic       in_valid_r;
  srst_res_t  core_res;
  srst_res_t  out_res_r;
  logic       out_valid_r;
  logic       has_result;
  logic       out_free;
  logic       fire;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r      <= 32'd0;
      accel_r      <= 32'd0;
      cruise_r     <= 32'd0;
      trap_r       <= 1'b0;
      repeat_r     <= 8'd1;
      end_delay_r  <= 16'd0;
      table_size_r <= 9'd0;
      ccw_r        <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_TOTAL_STEPS:   total_r      <= cfg_data;
        CFG_ACCEL_STEPS:   accel_r      <= cfg_data;
        CFG_CRUISE_STEPS:  cruise_r     <= cfg_data;
        CFG_TRAPEZOIDAL:   trap_r       <= cfg_data[0];
        CFG_REPEAT_FACTOR: repeat_r     <= cfg_data[7:0];
        CFG_END_DELAY:     end_delay_r  <= cfg_data[15:0];
        CFG_TABLE_SIZE:    table_size_r <= cfg_data[8:0];
        CFG_CCW:           ccw_r        <= cfg_data[0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    accel_cruise_r <= accel_r + cruise_r;
  end

  assign cfg.total_steps      = total_r;
  assign cfg.accel_steps      = accel_r;
  assign cfg.accel_cruise     = accel_cruise_r;
  assign cfg.trapezoidal      = trap_r;
  assign cfg.repeat_factor    = repeat_r;
  assign cfg.end_delay        = end_delay_r;
  assign cfg.table_size       = table_size_r;
  assign cfg.counterclockwise = ccw_r;

  // an item advances unless it makes a result that has nowhere to go
  assign out_free  = !out_valid_r || out_tready;
  assign fire      = in_valid_r && (!has_result || out_free);
  assign in_tready = !in_valid_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_item_r.opcode     <= in_tuser[1:0];
      in_item_r.table_addr <= in_tdata[7:0];
      in_item_r.table_data <= in_tdata[23:8];
    end
  end

  srst_core #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .item       (in_item_r),
    .fire       (fire),
    .has_result (has_result),
    .res        (core_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire && has_result) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && has_result) begin
      out_res_r <= core_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_res_r.position, out_res_r.compare_value,
                       out_res_r.next_delay, out_res_r.step_toggle};
  assign out_tuser  = out_res_r.phase;
  assign out_tlast  = out_res_r.finished;

endmodule

`default_nettype wire

>>> hdl/srst_checker.sv
// Port-level checks on the result channel of the stepper ramp step timer, bound to the top.
`default_nettype none

module srst_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            out_tvalid,
  input wire logic                            out_tready,
  input wire logic [srst_pkg::OUT_TDATA_W-1:0] out_tdata,
  input wire logic [srst_pkg::OUT_TUSER_W-1:0] out_tuser,
  input wire logic                            out_tlast
);
  import srst_pkg::*;

  // reset empties the result register
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("out_tvalid high after reset");

  // stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
      $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result changed");

  // the finishing step reports finished phase and no further delay
  a_last_finished: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> (out_tuser == PH_FINISHED) && (out_tdata[16:1] == 16'd0))
    else $error("finishing result with wrong phase or delay");

  // any other step is in a running ramp phase and toggles the step line
  a_running_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tdata[0] &&
      ((out_tuser == PH_ACCEL) || (out_tuser == PH_CRUISE) || (out_tuser == PH_DECEL)))
    else $error("non-final result outside a ramp phase");

endmodule

bind stepper_ramp_step_timer_top srst_checker u_srst_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

`default_nettype wire
